>>> rtl/smbd_pkg.sv
// ----------------------------------------------------------------------------
// smbd_pkg
// Types and constants shared by the smart beacon decision logic: send kinds,
// request types, register indexes, rule thresholds and the interval lookup.
// ----------------------------------------------------------------------------
package smbd_pkg;

  // kind of beacon produced by one request
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SMART   = 2'd1,
    KIND_STANDBY = 2'd2
  } kind_t;

  // request types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // register indexes (byte address bit 2)
  localparam logic REG_STANDBY_LIMIT = 1'b0;
  localparam logic REG_RATE_SETTING  = 1'b1;

  // register reset values
  localparam logic [15:0] STANDBY_LIMIT_RESET = 16'd180;
  localparam logic [2:0]  RATE_SETTING_RESET  = 3'd1;

  // rate code that turns smart beaconing off
  localparam logic [2:0] RATE_OFF = 3'd0;

  // rule thresholds
  localparam logic [7:0] MIN_WAIT    = 8'd10;
  localparam logic [8:0] TURN_LIMIT  = 9'd25;
  localparam logic [8:0] HALF_CIRCLE = 9'd180;
  localparam logic [8:0] FULL_CIRCLE = 9'd360;

  // beacon interval in seconds for each rate code
  function automatic logic [7:0] interval_sec(input logic [2:0] rate);
    logic [7:0] sec;
    case (rate)
      3'd2:    sec = 8'd40;
      3'd3:    sec = 8'd60;
      3'd4:    sec = 8'd90;
      3'd5:    sec = 8'd120;
      default: sec = 8'd20;
    endcase
    return sec;
  endfunction

endpackage

>>> rtl/smart_beacon_decision_unit.sv
// ----------------------------------------------------------------------------
// smart_beacon_decision_unit
// Decides per request whether a position beacon is sent: tick requests advance
// a saturating wait counter, evaluate requests apply the smart beaconing rule.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle unless stalled and presents its send
// decision in the cycle after acceptance in an output register; the next request
// is accepted in the same cycle that the waiting decision is taken, or at once
// while the output register is empty. The whole rule (wait counter compare, standby
// check, shortest heading change and interval compare) is evaluated between the
// request port and output register, with the wait counter and last heading updated
// at the same edge, so consecutive requests see each other's state without bubbles.
// Registers: standby_limit at byte address 0, rate_setting at byte address 4.
module smart_beacon_decision_unit #(
  parameter int WAIT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic        fix_locked,
  input  logic [9:0]  speed_knots,
  input  logic        heading_valid,
  input  logic [8:0]  heading_deg,
  // result channel
  output logic        send_valid,
  input  logic        send_ready,
  output logic [1:0]  send_kind,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CMP_WIDTH = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;

  // configuration registers
  logic [15:0] standby_limit;
  logic [2:0]  rate_setting;

  // decision state
  logic [WAIT_WIDTH-1:0] wait_seconds;
  logic [WAIT_WIDTH-1:0] wait_seconds_next;
  logic [8:0]            last_heading;
  logic [8:0]            last_heading_next;
  smbd_pkg::kind_t       kind_next;
  smbd_pkg::kind_t       kind;

  logic accept;
  logic cfg_write;

  // rule terms
  logic [CMP_WIDTH-1:0] wait_ext;
  logic [CMP_WIDTH-1:0] limit_ext;
  logic [8:0]           head_diff;
  logic                 turn_hit;
  logic                 below_min;
  logic                 over_standby;
  logic                 over_interval;
  logic                 motion_ok;

  assign accept    = req_valid && req_ready;
  assign req_ready = !send_valid || send_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      standby_limit <= smbd_pkg::STANDBY_LIMIT_RESET;
      rate_setting  <= smbd_pkg::RATE_SETTING_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        smbd_pkg::REG_STANDBY_LIMIT: standby_limit <= pwdata[15:0];
        smbd_pkg::REG_RATE_SETTING:  rate_setting  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      smbd_pkg::REG_STANDBY_LIMIT: prdata = {16'd0, standby_limit};
      smbd_pkg::REG_RATE_SETTING:  prdata = {29'd0, rate_setting};
      default:                     prdata = 32'd0;
    endcase
  end

  // compare terms
  assign wait_ext     = CMP_WIDTH'(wait_seconds);
  assign limit_ext    = CMP_WIDTH'(standby_limit);
  assign below_min    = wait_seconds < WAIT_WIDTH'(smbd_pkg::MIN_WAIT);
  assign over_standby = wait_ext > limit_ext;
  assign over_interval =
    wait_seconds > WAIT_WIDTH'(smbd_pkg::interval_sec(rate_setting));
  assign motion_ok    = fix_locked && (speed_knots != 10'd0) && heading_valid;

  // shortest heading change above the turn limit
  assign head_diff = (heading_deg > last_heading) ? heading_deg - last_heading
                                                  : last_heading - heading_deg;
  always_comb begin
    if (head_diff > smbd_pkg::FULL_CIRCLE) begin
      turn_hit = 1'b1;
    end else if (head_diff > smbd_pkg::HALF_CIRCLE) begin
      turn_hit = (smbd_pkg::FULL_CIRCLE - head_diff) > smbd_pkg::TURN_LIMIT;
    end else begin
      turn_hit = head_diff > smbd_pkg::TURN_LIMIT;
    end
  end

  // beacon rule and state update
  always_comb begin
    wait_seconds_next = wait_seconds;
    last_heading_next = last_heading;
    kind_next         = smbd_pkg::KIND_NONE;
    if (req_type == smbd_pkg::REQ_TICK) begin
      if (wait_seconds != {WAIT_WIDTH{1'b1}}) begin
        wait_seconds_next = wait_seconds + WAIT_WIDTH'(1);
      end
    end else if (rate_setting == smbd_pkg::RATE_OFF || below_min) begin
      kind_next = smbd_pkg::KIND_NONE;
    end else if (over_standby) begin
      wait_seconds_next = '0;
      kind_next         = smbd_pkg::KIND_STANDBY;
    end else if (motion_ok && (turn_hit || over_interval)) begin
      wait_seconds_next = '0;
      last_heading_next = heading_deg;
      kind_next         = smbd_pkg::KIND_SMART;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_seconds <= '0;
      last_heading <= '0;
      send_valid   <= 1'b0;
    end else begin
      if (accept) begin
        wait_seconds <= wait_seconds_next;
        last_heading <= last_heading_next;
        send_valid   <= 1'b1;
      end else if (send_ready) begin
        send_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= kind_next;
    end
  end

  assign send_kind = kind;

  // checks
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> send_valid)
    else $error("accepted request gave no result");

  a_tick_no_send: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == smbd_pkg::REQ_TICK) |=> send_kind == smbd_pkg::KIND_NONE)
    else $error("tick request produced a send");

  a_send_clears_wait: assert property (@(posedge clk) disable iff (rst)
    (accept && kind_next != smbd_pkg::KIND_NONE) |=> wait_seconds == '0)
    else $error("send did not clear the wait counter");

  a_heading_only_on_smart: assert property (@(posedge clk) disable iff (rst)
    (accept && kind_next != smbd_pkg::KIND_SMART) |=> $stable(last_heading))
    else $error("last heading changed without a smart send");

endmodule
